[rtl/core/subarray_sum_count_macros.svh]
// ----------------------------------------------------------------------------
// subarray_sum_count assertion macros
// concurrent assertion shorthands clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef SUBARRAY_SUM_COUNT_MACROS_SVH
`define SUBARRAY_SUM_COUNT_MACROS_SVH

// property that must hold at every clock edge
`define SSC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// condition that must be followed by another in the next cycle
`define SSC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/ssc_pkg.sv]
// ----------------------------------------------------------------------------
// ssc_pkg
// shared constants, types and helpers of the subarray sum counter
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int OCC_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int VALUE_W  = 16;
    localparam int TARGET_W = 24;
    localparam int TOTAL_W  = 25;
    localparam int COUNT_W  = 16;

    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [OCC_W-1:0]    OCC_FULL     = OCC_W'(WINDOW_DEPTH);

    typedef struct packed {
        logic [OCC_W-1:0]   occupancy;
        logic [TOTAL_W-1:0] total;
    } status_t;

    function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] result;
        if (idx == ADDR_W'(WINDOW_DEPTH - 1))
        begin
            result = '0;
        end
        else
        begin
            result = idx + ADDR_W'(1);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ssc_window_ram.sv]
// ----------------------------------------------------------------------------
// ssc_window_ram
// single write, single registered read memory with write-first bypass
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_window_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ssc_core.sv]
// ----------------------------------------------------------------------------
// ssc_core
// sequencer and shared adder that push, trim and match the sliding window
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [ssc_pkg::TARGET_W-1:0] target,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ssc_pkg::VALUE_W-1:0]  in_value,
    input  wire logic                         in_last,
    input  wire logic                         out_free,
    output logic                              out_load,
    output logic      [ssc_pkg::COUNT_W-1:0]  out_count,
    output logic                              out_overflow,
    output ssc_pkg::status_t                  status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_TRIM,
        S_EMIT
    } state_t;

    state_t                         state_reg, state_next;
    logic [ssc_pkg::VALUE_W-1:0]    value_reg, value_next;
    logic                           last_reg, last_next;
    logic [ssc_pkg::ADDR_W-1:0]     head_reg, head_next;
    logic [ssc_pkg::ADDR_W-1:0]     tail_reg, tail_next;
    logic [ssc_pkg::OCC_W-1:0]      occ_reg, occ_next;
    logic [ssc_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [ssc_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                           ovf_reg, ovf_next;

    logic                           ram_we;
    logic [ssc_pkg::VALUE_W-1:0]    ram_rdata;
    logic [ssc_pkg::TOTAL_W-1:0]    target_ext;
    logic [ssc_pkg::TOTAL_W-1:0]    front_ext;
    logic [ssc_pkg::TOTAL_W-1:0]    value_ext;

    // rdata always holds the entry at head_reg, read ahead from head_next
    ssc_window_ram #(
        .DEPTH  (ssc_pkg::WINDOW_DEPTH),
        .DATA_W (ssc_pkg::VALUE_W),
        .ADDR_W (ssc_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (value_reg),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    assign target_ext = ssc_pkg::TOTAL_W'(target);
    assign front_ext  = ssc_pkg::TOTAL_W'(ram_rdata);
    assign value_ext  = ssc_pkg::TOTAL_W'(value_reg);

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        last_next  = last_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        total_next = total_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        ram_we     = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = in_value;
                    last_next  = in_last;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                ram_we    = 1'b1;
                tail_next = ssc_pkg::next_index(tail_reg);
                if (occ_reg == ssc_pkg::OCC_FULL)
                begin
                    // store full: oldest entry leaves as the new one lands
                    head_next  = ssc_pkg::next_index(head_reg);
                    total_next = total_reg - front_ext + value_ext;
                    ovf_next   = 1'b1;
                end
                else
                begin
                    occ_next   = occ_reg + ssc_pkg::OCC_W'(1);
                    total_next = total_reg + value_ext;
                end
                state_next = S_TRIM;
            end
            S_TRIM:
            begin
                if ((total_reg > target_ext) && (occ_reg != '0))
                begin
                    head_next  = ssc_pkg::next_index(head_reg);
                    occ_next   = occ_reg - ssc_pkg::OCC_W'(1);
                    total_next = total_reg - front_ext;
                end
                else
                begin
                    if ((total_reg == target_ext) && (count_reg != ssc_pkg::COUNT_MAX))
                    begin
                        count_next = count_reg + ssc_pkg::COUNT_W'(1);
                    end
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                    occ_next   = '0;
                    total_next = '0;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            total_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            total_reg <= total_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_count        = count_reg;
    assign out_overflow     = ovf_reg;
    assign status.occupancy = occ_reg;
    assign status.total     = total_reg;

endmodule

`default_nettype wire

[rtl/core/subarray_sum_count.sv]
// ----------------------------------------------------------------------------
// subarray_sum_count
// counts contiguous runs of a positive sequence whose sum equals a target
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one element per transaction: tdata = value, tlast marks
//   the final element of a sequence. m_axis carries one transaction per
//   sequence, issued after the element marked last: tdata = match_count,
//   tuser[0] = overflow (the 1024-entry window store dropped an element).
//   cfg_we/cfg_wdata write target_sum (reset value 1); write only when idle.
// sequencing
//   an element is taken in idle and written to the window store in push;
//   trim then drops elements from the window front, one per pass through the
//   shared subtractor, with the window store read ahead. a last element then
//   loads the result register. s_axis_tready is low while an element is in work.
// reset and stall
//   reset empties the window, clears count and overflow and drops any
//   pending result; target_sum returns to 1. a stalled m_axis holds its
//   result; the block keeps taking elements and waits only when the next
//   result is due while the previous one is still held.
// ----------------------------------------------------------------------------
`default_nettype none
`include "subarray_sum_count_macros.svh"

module subarray_sum_count (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata,     // target_sum
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // value
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,  // match_count
    output logic      [0:0]  m_axis_tuser   // overflow
);

    logic [ssc_pkg::TARGET_W-1:0] target_reg;
    logic                         m_valid_reg, m_valid_next;
    logic [ssc_pkg::COUNT_W-1:0]  m_count_reg;
    logic                         m_ovf_reg;

    logic                         out_free;
    logic                         out_load;
    logic [ssc_pkg::COUNT_W-1:0]  out_count;
    logic                         out_overflow;
    ssc_pkg::status_t             core_status;

    ssc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .target       (target_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_value     (s_axis_tdata),
        .in_last      (s_axis_tlast),
        .out_free     (out_free),
        .out_load     (out_load),
        .out_count    (out_count),
        .out_overflow (out_overflow),
        .status       (core_status)
    );

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= ssc_pkg::TARGET_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_count_reg <= out_count;
            m_ovf_reg   <= out_overflow;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_count_reg;
    assign m_axis_tuser[0] = m_ovf_reg;

    `SSC_ASSERT_ALWAYS(a_occ_bound, core_status.occupancy <= ssc_pkg::OCC_FULL, "window occupancy above depth")
    `SSC_ASSERT_ALWAYS(a_empty_total, (core_status.occupancy != '0) || (core_status.total == '0), "empty window with nonzero total")
    `SSC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "element taken while previous one in work")

endmodule

`default_nettype wire

[tb/subarray_sum_count_checker.sv]
// ----------------------------------------------------------------------------
// subarray_sum_count checker
// watches the element and result streams and the target register port,
// keeps its own sliding window to work out each sequence's match count and
// overflow flag, and compares every result transaction with the oldest one
// still waiting
// ----------------------------------------------------------------------------
module subarray_sum_count_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ssc_pkg::TARGET_W-1:0] cfg_wdata,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [ssc_pkg::VALUE_W-1:0]  s_axis_tdata,
    input  logic                         s_axis_tlast,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [ssc_pkg::COUNT_W-1:0]  m_axis_tdata,
    input  logic [0:0]                   m_axis_tuser,
    output int                           fail_count,
    output int                           tally_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ssc_pkg::COUNT_W-1:0] hits;
        logic                        lost;
    } tally_t;

    logic [ssc_pkg::VALUE_W-1:0]  win_mem [ssc_pkg::WINDOW_DEPTH];
    int                           win_head;
    int                           win_tail;
    int                           win_fill;
    logic [ssc_pkg::TOTAL_W-1:0]  win_sum;
    logic [ssc_pkg::COUNT_W-1:0]  hit_count;
    logic                         spill_seen;
    logic [ssc_pkg::TARGET_W-1:0] target_reg;
    tally_t                       tally_q [$];

    task automatic flag_failure(input string detail);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%s", detail);
        end
    endtask

    task automatic clear_window();
        win_head   = 0;
        win_tail   = 0;
        win_fill   = 0;
        win_sum    = '0;
        hit_count  = '0;
        spill_seen = 1'b0;
    endtask

    task automatic drop_oldest();
        win_sum  = win_sum - ssc_pkg::TOTAL_W'(win_mem[win_head]);
        win_head = (win_head + 1) % ssc_pkg::WINDOW_DEPTH;
        win_fill--;
    endtask

    task automatic absorb_element(input logic [ssc_pkg::VALUE_W-1:0] v, input logic is_last);
        tally_t t;
        // full window loses its oldest element
        if (win_fill >= ssc_pkg::WINDOW_DEPTH)
        begin
            drop_oldest();
            spill_seen = 1'b1;
        end
        win_mem[win_tail] = v;
        win_tail = (win_tail + 1) % ssc_pkg::WINDOW_DEPTH;
        win_fill++;
        win_sum = win_sum + ssc_pkg::TOTAL_W'(v);
        while (win_sum > ssc_pkg::TOTAL_W'(target_reg) && win_fill > 0)
        begin
            drop_oldest();
        end
        if (win_sum == ssc_pkg::TOTAL_W'(target_reg) && hit_count != ssc_pkg::COUNT_MAX)
        begin
            hit_count++;
        end
        if (is_last)
        begin
            t.hits = hit_count;
            t.lost = spill_seen;
            tally_q.insert(tally_q.size(), t);
            clear_window();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tally_t want;
        if (!rst_n)
        begin
            target_reg = ssc_pkg::TARGET_RESET;
            clear_window();
            tally_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (tally_q.size() == 0)
                begin
                    flag_failure($sformatf("unexpected result: count %0d overflow %0d",
                                           m_axis_tdata, m_axis_tuser[0]));
                end
                else
                begin
                    want = tally_q.pop_front();
                    if (m_axis_tdata !== want.hits)
                    begin
                        flag_failure($sformatf("match_count mismatch: expected %0d, got %0d",
                                               want.hits, m_axis_tdata));
                    end
                    if (m_axis_tuser[0] !== want.lost)
                    begin
                        flag_failure($sformatf("overflow mismatch: expected %0d, got %0d",
                                               want.lost, m_axis_tuser[0]));
                    end
                end
            end
            if (cfg_we)
            begin
                target_reg = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_element(s_axis_tdata, s_axis_tlast);
            end
        end
        tally_pending = tally_q.size();
    end

endmodule

[tb/subarray_sum_count_tb.sv]
// ----------------------------------------------------------------------------
// subarray_sum_count testbench
// drives element sequences under several targets: a short directed set and
// random sequences built mostly from runs that hit the target; the checker
// scores every result and the top gives the verdict
// ----------------------------------------------------------------------------
module subarray_sum_count_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [ssc_pkg::TARGET_W-1:0] TARGET_TOP = '1;
    localparam logic [ssc_pkg::VALUE_W-1:0]  VALUE_TOP  = '1;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [ssc_pkg::TARGET_W-1:0] cfg_wdata = '0;
    logic                         s_valid = 1'b0;
    logic [ssc_pkg::VALUE_W-1:0]  s_data = '0;
    logic                         s_last = 1'b0;
    logic                         m_ready = 1'b0;
    logic                         s_ready;
    logic                         m_valid;
    logic [ssc_pkg::COUNT_W-1:0]  m_data;
    logic [0:0]                   m_user;

    int                           fail_count;
    int                           tally_pending;
    int                           send_idle_pct = 0;
    int                           recv_idle_pct = 0;
    int                           quiet_cycles = 0;
    logic [ssc_pkg::TARGET_W-1:0] cur_target = ssc_pkg::TARGET_RESET;

    always #2 clk = ~clk;

    subarray_sum_count dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    subarray_sum_count_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .fail_count    (fail_count),
        .tally_pending (tally_pending)
    );

    always @(posedge clk)
    begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [ssc_pkg::VALUE_W-1:0] v, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        s_last  <= l;
        do
        begin
            @(posedge clk);
        end
        while (!s_ready);
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (tally_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic retarget(input logic [ssc_pkg::TARGET_W-1:0] v);
        s_valid <= 1'b0;
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_target = v;
    endtask

    // mostly runs that sum exactly to the target, mixed with noise
    task automatic stream_random(input int n_items);
        int remaining;
        int run_len;
        int sent;
        int cap;
        int pick;
        logic [ssc_pkg::VALUE_W-1:0] v;
        logic l;
        remaining = int'(cur_target);
        run_len   = ($urandom_range(99) < 90) ? $urandom_range(1, 24) : $urandom_range(25, 200);
        sent      = 0;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                cap = (remaining < 65535) ? remaining : 65535;
                v = ssc_pkg::VALUE_W'($urandom_range(1, cap));
                remaining -= int'(v);
                if (remaining == 0)
                begin
                    remaining = int'(cur_target);
                end
            end
            else if (pick < 90)
            begin
                v = ssc_pkg::VALUE_W'($urandom_range(1, 65535));
            end
            else
            begin
                v = ssc_pkg::VALUE_W'($urandom_range(1, 16));
            end
            sent++;
            l = (sent >= run_len) || (i == n_items - 1);
            send_item(v, l);
            if (l)
            begin
                sent      = 0;
                remaining = int'(cur_target);
                run_len   = ($urandom_range(99) < 90) ? $urandom_range(1, 24)
                                                       : $urandom_range(25, 200);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // target at its reset value
        send_item(16'd1, 1'b1);
        send_item(VALUE_TOP, 1'b0);
        send_item(16'd1, 1'b0);
        send_item(16'd1, 1'b1);

        retarget(24'd65535);
        send_item(VALUE_TOP, 1'b0);
        send_item(VALUE_TOP, 1'b0);
        send_item(16'd32768, 1'b0);
        send_item(16'd32767, 1'b0);
        send_item(16'd1, 1'b1);
        send_item(VALUE_TOP, 1'b1);

        retarget(TARGET_TOP);
        send_item(VALUE_TOP, 1'b0);
        send_item(VALUE_TOP, 1'b0);
        send_item(VALUE_TOP, 1'b1);

        send_idle_pct = 18;
        recv_idle_pct = 55;
        retarget(TARGET_TOP);
        stream_random(100);
        retarget(24'd1000);
        stream_random(110);

        send_idle_pct = 55;
        recv_idle_pct = 18;
        retarget(24'd1);
        stream_random(100);
        retarget(24'd70000);
        stream_random(110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        retarget(24'd300);
        stream_random(100);
        retarget(24'd5000000);
        stream_random(130);

        s_valid <= 1'b0;
        wait_drained();
        if (fail_count == 0 && tally_pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ssc_pkg.sv
rtl/core/ssc_window_ram.sv
rtl/core/ssc_core.sv
rtl/core/subarray_sum_count.sv
tb/subarray_sum_count_checker.sv
tb/subarray_sum_count_tb.sv
